[hdl/obdmf_pkg.sv]
// Shared constants and length lookup functions for the OBD message framer.
`default_nettype none
package obdmf_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned POS_W  = 3;
	localparam int unsigned LEN_W  = 3;

	// mode lookup codes (4 bits: 1..7 are lengths)
	localparam logic [3:0] MLEN_BAD      = 4'd0;
	localparam logic [3:0] MLEN_NEED_PID = 4'd8;

	localparam logic [BYTE_W-1:0] MODE_RSP_PID   = 8'h41;
	localparam logic [BYTE_W-1:0] MODE_RSP_FRZ   = 8'h42;
	localparam logic [BYTE_W-1:0] MODE_RSP_CODES = 8'h43;
	localparam logic [BYTE_W-1:0] MODE_RSP_CLEAR = 8'h44;
	localparam logic [BYTE_W-1:0] MODE_RSP_TID   = 8'h45;
	localparam logic [BYTE_W-1:0] MODE_RSP_INFO  = 8'h49;

	localparam logic [POS_W-1:0] POS_MAX = 3'd6;

	localparam logic [LEN_W-1:0] REQ_LEN [10] = '{
		3'd0, 3'd2, 3'd3, 3'd1, 3'd1, 3'd2, 3'd2, 3'd1, 3'd7, 3'd2
	};

	// Length from the mode byte alone.
	function automatic logic [3:0] len_from_mode(input logic [BYTE_W-1:0] m);
		logic [3:0] r;
		r = MLEN_BAD;
		if (m <= 8'd9) begin
			r = {1'b0, REQ_LEN[m[3:0]]};
		end else begin
			case (m) inside
				MODE_RSP_PID, MODE_RSP_FRZ, MODE_RSP_TID, MODE_RSP_INFO: r = MLEN_NEED_PID;
				MODE_RSP_CODES, [8'h46:8'h48]: r = 4'd7;
				MODE_RSP_CLEAR: r = 4'd1;
				default: r = MLEN_BAD;
			endcase
		end
		return r;
	endfunction

	// Length from mode and PID/TID/infotype byte; zero when unframable.
	function automatic logic [LEN_W-1:0] len_from_pid(input logic [BYTE_W-1:0] m,
			input logic [BYTE_W-1:0] p);
		logic [LEN_W-1:0] r;
		logic             low_zero;
		low_zero = (p[4:0] == 5'd0);
		r = '0;
		if (m == MODE_RSP_TID) begin
			if (low_zero) r = 3'd7;
			else if (p <= 8'd4) r = 3'd4;
			else r = 3'd6;
		end else if (m == MODE_RSP_INFO) begin
			if (low_zero || p[0]) r = 3'd7;
			else r = 3'd3;
		end else if (m == MODE_RSP_PID || m == MODE_RSP_FRZ) begin
			if (low_zero) begin
				r = 3'd6;
			end else begin
				case (p) inside
					8'h01: r = (m == MODE_RSP_FRZ) ? 3'd0 : 3'd6;
					8'h02: r = (m == MODE_RSP_PID) ? 3'd0 : 3'd4;
					8'h03, 8'h0c, 8'h10, 8'h1f, [8'h14:8'h1b]: r = 3'd4;
					[8'h04:8'h0b], [8'h0d:8'h0f], [8'h11:8'h13], [8'h55:8'h58]: r = 3'd3;
					[8'h1c:8'h1e]: r = 3'd2;
					default: r = 3'd0;
				endcase
			end
			// frame-number byte on freeze-frame replies
			if (m == MODE_RSP_FRZ && r != 3'd0) r = r + 3'd1;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[hdl/obd_message_framer_core.sv]
// OBD message framer: splits a stripped diagnostic byte stream into messages.
//
// Input stream s_axis: one message byte per beat (tdata[7:0]).
// Output stream m_axis: one beat per input byte. tdata[7:0] is the byte,
// tdata[10:8] its position in the message (0 is the mode), upper bits zero.
// tlast marks the byte that completes or aborts a message; tuser[0] flags an
// unframable mode or PID (always together with tlast), after which the next
// byte starts a fresh message.
// A byte is taken into an input register, the length lookup and counter
// logic run combinationally on it, and the result lands in an output
// register; while m_axis does not stall, one byte per cycle is sustained.
// The input register advances whenever the output register is empty or is
// being taken, so a stall on m_axis holds one byte in each register and
// then drops s_axis_tready.
// Reset clears both registers and the framing state; the block then waits
// for a mode byte.
`default_nettype none
module obd_message_framer_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,   // [7:0] out_byte, [10:8] byte_position
	output logic             m_axis_tlast,   // message_end
	output logic [0:0]       m_axis_tuser    // [0] frame_error
);
	import obdmf_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              valid_s2;
	logic [BYTE_W-1:0] byte_s2;
	logic [POS_W-1:0]  pos_s2;
	logic              end_s2;
	logic              err_s2;

	logic [POS_W-1:0]  bytes_seen_q;
	logic [BYTE_W-1:0] mode_seen_q;
	logic [LEN_W-1:0]  exp_len_q;
	logic              len_known_q;

	logic              advance;
	logic [3:0]        mode_len;
	logic [LEN_W-1:0]  pid_len;
	logic [POS_W:0]    pos_inc;
	logic              msg_end;
	logic              msg_err;
	logic [BYTE_W-1:0] nxt_mode;
	logic [LEN_W-1:0]  nxt_len;
	logic              nxt_known;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	assign mode_len = len_from_mode(byte_s1);
	assign pid_len  = len_from_pid(mode_seen_q, byte_s1);
	assign pos_inc  = {1'b0, bytes_seen_q} + {{POS_W{1'b0}}, 1'b1};

	always_comb begin
		msg_end   = 1'b0;
		msg_err   = 1'b0;
		nxt_mode  = mode_seen_q;
		nxt_len   = exp_len_q;
		nxt_known = len_known_q;
		if (bytes_seen_q == '0) begin
			nxt_mode = byte_s1;
			if (mode_len == MLEN_BAD) begin
				msg_err = 1'b1;
			end else if (mode_len == MLEN_NEED_PID) begin
				nxt_known = 1'b0;
			end else begin
				nxt_len   = mode_len[LEN_W-1:0];
				nxt_known = 1'b1;
				msg_end   = (mode_len <= 4'd1);
			end
		end else if (!len_known_q) begin
			if (pid_len == '0) begin
				msg_err = 1'b1;
			end else begin
				nxt_len   = pid_len;
				nxt_known = 1'b1;
				msg_end   = (pos_inc >= {1'b0, pid_len});
			end
		end else begin
			// count overrun guard: position six is always the last byte
			msg_end = (pos_inc >= {1'b0, exp_len_q}) || (bytes_seen_q >= POS_MAX);
		end
		if (msg_err) msg_end = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			bytes_seen_q <= '0;
			mode_seen_q  <= '0;
			exp_len_q    <= '0;
			len_known_q  <= 1'b0;
		end else begin
			if (s_axis_tready) valid_s1 <= s_axis_tvalid;
			if (advance) valid_s2 <= 1'b1;
			else if (m_axis_tready) valid_s2 <= 1'b0;
			if (advance) begin
				if (msg_end) begin
					bytes_seen_q <= '0;
					mode_seen_q  <= '0;
					exp_len_q    <= '0;
					len_known_q  <= 1'b0;
				end else begin
					bytes_seen_q <= pos_inc[POS_W-1:0];
					mode_seen_q  <= nxt_mode;
					exp_len_q    <= nxt_len;
					len_known_q  <= nxt_known;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) byte_s1 <= s_axis_tdata;
		if (advance) begin
			byte_s2 <= byte_s1;
			pos_s2  <= bytes_seen_q;
			end_s2  <= msg_end;
			err_s2  <= msg_err;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {5'd0, pos_s2, byte_s2};
	assign m_axis_tlast  = end_s2;
	assign m_axis_tuser  = err_s2;

endmodule
`default_nettype wire
